[design/rrilg_pkg.sv]
// shared types and constants for the lagged random rr interval generator
// no dependencies; imported by every module of the block
package rrilg_pkg;

  localparam int IV_W        = 18;  // interval width, 16 fraction bits
  localparam int SP_W        = 16;  // spread width
  localparam int LAG_W       = 5;   // lag register width
  localparam int FRAC_W      = 16;  // random fraction width
  localparam int CFG_DW      = 32;  // config data width
  localparam int CFG_AW      = 4;   // config byte address width
  localparam int DEF_MAX_LAG = 16;

  localparam logic [IV_W-1:0]  MEAN_RST   = IV_W'(56361);
  localparam logic [SP_W-1:0]  SPREAD_RST = SP_W'(4588);
  localparam logic [LAG_W-1:0] LAG_RST    = LAG_W'(6);
  localparam logic [IV_W-1:0]  IV_MAX     = '1;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MEAN   = 2'd0;
  localparam logic [1:0] REG_SPREAD = 2'd1;
  localparam logic [1:0] REG_LAG    = 2'd2;

  // history access request from the sequencer
  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [IV_W-1:0] wr_data;
  } hist_req_t;

endpackage

[design/rrilg_hist.sv]
// interval history: circular memory with per-entry valid bits and write pointer
// depends on rrilg_pkg; entries not written since restart read as the mean
module rrilg_hist #(
  parameter int MAX_LAG = rrilg_pkg::DEF_MAX_LAG
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  rrilg_pkg::hist_req_t        req,
  input  logic [rrilg_pkg::LAG_W-1:0] lag,
  input  logic [rrilg_pkg::IV_W-1:0]  mean,
  output logic [rrilg_pkg::IV_W-1:0]  rd_data
);
  import rrilg_pkg::*;

  localparam int AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int CW = ($clog2(2 * MAX_LAG) + 1 > LAG_W) ? $clog2(2 * MAX_LAG) + 1 : LAG_W + 1;

  logic [IV_W-1:0]    mem [MAX_LAG];
  logic [MAX_LAG-1:0] valid_r;
  logic [AW-1:0]      wp_r;
  logic [IV_W-1:0]    raw_r;
  logic               rvalid_r;

  logic [CW-1:0] lag_ext;
  logic [CW-1:0] eff_lag;
  logic [CW-1:0] wp_ext;
  logic [CW-1:0] ridx_full;
  logic [AW-1:0] ridx;

  // clamp lag into 1..MAX_LAG, then step back from the write pointer
  always_comb begin
    lag_ext = CW'(lag);
    if (lag_ext == '0) begin
      eff_lag = CW'(1);
    end else if (lag_ext > CW'(MAX_LAG)) begin
      eff_lag = CW'(MAX_LAG);
    end else begin
      eff_lag = lag_ext;
    end
    wp_ext = CW'(wp_r);
    if (wp_ext >= eff_lag) begin
      ridx_full = wp_ext - eff_lag;
    end else begin
      ridx_full = wp_ext + CW'(MAX_LAG) - eff_lag;
    end
    ridx = ridx_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wp_r] <= req.wr_data;
    end
    if (req.rd_en) begin
      raw_r <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      valid_r  <= '0;
      wp_r     <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rvalid_r <= valid_r[ridx];
      end
      if (req.wr_en) begin
        valid_r[wp_r] <= 1'b1;
        if (wp_r == AW'(MAX_LAG - 1)) begin
          wp_r <= '0;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
    end
  end

  assign rd_data = rvalid_r ? raw_r : mean;

endmodule

[design/rrilg_core.sv]
// sequencer with one shared 16x16 multiplier and a bit-pair square root step
// depends on rrilg_pkg; drives history requests and holds the result register
module rrilg_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rrilg_pkg::FRAC_W-1:0] in_random_fraction,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rrilg_pkg::IV_W-1:0]   out_interval,
  output logic                         out_held,
  input  logic [rrilg_pkg::IV_W-1:0]   mean,
  input  logic [rrilg_pkg::SP_W-1:0]   spread,
  input  logic [rrilg_pkg::IV_W-1:0]   past,
  output rrilg_pkg::hist_req_t         hreq
);
  import rrilg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_DIST = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_MUL3 = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam int RW = 2 * SP_W;  // radicand width
  localparam int MW = 2 * SP_W;  // product width

  logic [3:0]        state_r;
  logic [3:0]        cnt_r;
  logic [FRAC_W-1:0] frac_r;
  logic [IV_W-1:0]   dist_r;
  logic [RW-1:0]     acc_r;
  logic [SP_W+1:0]   rem_r;
  logic [SP_W-1:0]   root_r;
  logic [SP_W:0]     off_r;
  logic [IV_W-1:0]   result_r;
  logic              held_r;
  logic              out_valid_r;
  logic [IV_W-1:0]   out_interval_r;
  logic              out_held_r;

  logic [SP_W-1:0] mul_a;
  logic [SP_W-1:0] mul_b;
  logic [MW-1:0]   prod;
  logic [IV_W-1:0] deviation;
  logic [SP_W+3:0] rem_sh;
  logic [SP_W+3:0] trial;
  logic            ge;
  logic [SP_W+3:0] rem_sub;
  logic signed [IV_W+1:0] val;
  logic            accept;
  logic            out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_MUL2: begin
        mul_a = dist_r[SP_W-1:0];
        mul_b = dist_r[SP_W-1:0];
      end
      S_MUL3: begin
        mul_a = root_r;
        mul_b = frac_r;
      end
      default: begin
        mul_a = spread;
        mul_b = spread;
      end
    endcase
  end
  assign prod = MW'(mul_a) * MW'(mul_b);

  assign deviation = (past >= mean) ? (past - mean) : (mean - past);

  // one bit-pair step of the restoring square root
  assign rem_sh  = {rem_r, acc_r[RW-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  assign val = $signed({2'b00, mean}) - $signed({4'b0000, root_r})
             + $signed({3'b000, off_r});

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          frac_r <= in_random_fraction;
        end
      end
      S_DIST: begin
        dist_r   <= deviation;
        result_r <= past;
        held_r   <= (deviation > IV_W'(spread));
      end
      S_MUL1: begin
        acc_r <= prod;
      end
      S_MUL2: begin
        acc_r  <= acc_r - prod;
        rem_r  <= '0;
        root_r <= '0;
      end
      S_SQRT: begin
        rem_r  <= ge ? rem_sub[SP_W+1:0] : rem_sh[SP_W+1:0];
        root_r <= {root_r[SP_W-2:0], ge};
        acc_r  <= {acc_r[RW-3:0], 2'b00};
      end
      S_MUL3: begin
        off_r <= prod[MW-1 -: SP_W+1];  // 2*b*frac >> 16
      end
      S_FIN: begin
        if (val[IV_W+1]) begin
          result_r <= '0;
        end else if (val[IV_W]) begin
          result_r <= IV_MAX;
        end else begin
          result_r <= val[IV_W-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_interval_r <= result_r;
          out_held_r     <= held_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_DIST;
        S_DIST: begin
          state_r <= (deviation > IV_W'(spread)) ? S_DONE : S_MUL1;
        end
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: begin
          state_r <= S_SQRT;
          cnt_r   <= '0;
        end
        S_SQRT: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'hf) begin
            state_r <= S_MUL3;
          end
        end
        S_MUL3: state_r <= S_FIN;
        S_FIN:  state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    hreq.rd_en   = accept;
    hreq.wr_en   = (state_r == S_DONE) && out_free;
    hreq.wr_data = result_r;
  end

  assign out_valid    = out_valid_r;
  assign out_interval = out_interval_r;
  assign out_held     = out_held_r;

endmodule

[design/rr_interval_lagged_random_generator.sv]
// lagged random rr interval generator: one transaction at a time; in_stall stays high from
// acceptance until the result is loaded into the output register, and a held lagged interval
// skips the arithmetic; busy time is set by the 16-step square root and three passes through one multiplier
// reset (synchronous, rst_n low): registers to defaults, history reads as mean, pointer zero
// a register write refills the history the same way, at once, with no clearing pass
// depends on rrilg_pkg, rrilg_hist, rrilg_core
module rr_interval_lagged_random_generator #(
  parameter int MAX_LAG = rrilg_pkg::DEF_MAX_LAG
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rrilg_pkg::FRAC_W-1:0] in_random_fraction,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rrilg_pkg::IV_W-1:0]   out_interval,
  output logic                         out_held,
  // configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rrilg_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rrilg_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rrilg_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import rrilg_pkg::*;

  logic [IV_W-1:0]  mean_r;
  logic [SP_W-1:0]  spread_r;
  logic [LAG_W-1:0] lag_r;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        restart;
  hist_req_t   hreq;
  logic [IV_W-1:0] past;

  // register file, single access phase write, no wait states
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // a write to any real register restarts generation; unused addresses are ignored
  always_comb begin
    unique case (cfg_idx)
      REG_MEAN, REG_SPREAD, REG_LAG: restart = cfg_wr;
      default:                       restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r   <= MEAN_RST;
      spread_r <= SPREAD_RST;
      lag_r    <= LAG_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MEAN:   mean_r   <= cfg_pwdata[IV_W-1:0];
        REG_SPREAD: spread_r <= cfg_pwdata[SP_W-1:0];
        REG_LAG:    lag_r    <= cfg_pwdata[LAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (cfg_idx)
      REG_MEAN:   cfg_prdata = CFG_DW'(mean_r);
      REG_SPREAD: cfg_prdata = CFG_DW'(spread_r);
      REG_LAG:    cfg_prdata = CFG_DW'(lag_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // history of past intervals, read at the edge that accepts the transaction
  rrilg_hist #(
    .MAX_LAG (MAX_LAG)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .req     (hreq),
    .lag     (lag_r),
    .mean    (mean_r),
    .rd_data (past)
  );

  // sequencer and shared arithmetic; result register decouples the two channels
  rrilg_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_random_fraction (in_random_fraction),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_interval       (out_interval),
    .out_held           (out_held),
    .mean               (mean_r),
    .spread             (spread_r),
    .past               (past),
    .hreq               (hreq)
  );

endmodule
